>>> hdl/sekf_pkg.sv
// Shared types and constants of the scalar extended Kalman filter.
package sekf_pkg;

	localparam int WORD_W  = 48;
	localparam int NOISE_W = 47;
	localparam int KIND_W  = 2;
	localparam int HALF_W  = WORD_W / 2;
	localparam int IN_W    = 480;
	localparam int OUT_W   = 5 * WORD_W;
	localparam int CFG_IDX_W = 1;
	localparam int MUL_STEPS = 4;

	localparam logic [KIND_W-1:0] KIND_PREDICT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INIT    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'd1;

	localparam logic [WORD_W-1:0] LIM_POS = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] LIM_NEG = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL,
		ST_MULR,
		ST_DIV,
		ST_DIVR,
		ST_PR_FX,
		ST_PR_BU,
		ST_PR_X,
		ST_PR_FP,
		ST_PR_PF,
		ST_PR_Q,
		ST_UP_PH,
		ST_UP_HP,
		ST_UP_S,
		ST_UP_Y,
		ST_UP_K,
		ST_UP_KY,
		ST_UP_X,
		ST_UP_CL,
		ST_UP_IKH,
		ST_UP_P,
		ST_UP_PW,
		ST_DONE
	} state_t;

endpackage

>>> hdl/scalar_extended_kalman_filter.sv
// Top level: sequenced one-state extended Kalman filter with a shared multiplier and a divider.
//
// Input channel s_*: one transaction carries one step, its kind in s_tuser
// (0 predict, 1 update, 2 init, 3 no change) and all operands in s_tdata.
// Output channel m_*: one transaction per step with x, P, K, residual and S.
// Config channel cfg_*: always ready; index 0 writes Q, index 1 writes R.
// All values are signed fixed point with FRAC_BITS fraction bits, saturating.
//
// Every product goes through one 24x24 multiplier as four partial products
// and a rounding step, after an operand setup step. The gain quotient uses a
// restoring divider at one bit per cycle, 48 + FRAC_BITS quotient bits, then
// a rounding step. Init and kind 3 go straight to posting; a zero S skips the
// divider and keeps the held gain. One step is in work at a time; s_tready
// is high only while the sequencer is idle, from the cycle after a step posts.
// The result sits in an output register; the next step is taken while it
// waits, and a finished step holds in its last state until the receiver
// takes the previous result.
// Reset clears x, P, K, the overflow flag, Q and R and empties the output.
module scalar_extended_kalman_filter #(
	parameter int FRAC_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// drive_current, state_transition, control_gain, measurement,
	// predicted_output, sensitivity, state_low, state_high, init_state,
	// init_covariance, one zero pad bit
	input  logic [sekf_pkg::IN_W-1:0]            s_tdata,
	// kind
	input  logic [sekf_pkg::KIND_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// state_estimate, covariance, gain, residual, innovation_variance
	output logic [sekf_pkg::OUT_W-1:0]           m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sekf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sekf_pkg::NOISE_W-1:0]         cfg_data
);

	localparam int W   = sekf_pkg::WORD_W;
	localparam int HW  = sekf_pkg::HALF_W;
	localparam int NW  = W + FRAC_BITS;
	localparam int CW  = $clog2(NW + 1);
	localparam int PW  = 2 * W;
	localparam logic [W-1:0] FX_ONE = W'(1) << FRAC_BITS;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	function automatic logic [W-1:0] apply_sign(input logic [W-1:0] m, input logic neg);
		return neg ? (~m + W'(1)) : m;
	endfunction

	sekf_pkg::state_t state_q, state_d, ret_q, ret_d;

	logic signed [W-1:0] x_q, p_q, k_q;
	logic                ovf_q, ps_q;
	logic [sekf_pkg::NOISE_W-1:0] qn_q, rn_q;
	logic signed [W-1:0] u_q, f_q, b_q, z_q, hx_q, h_q, lo_q, hi_q;
	logic signed [W-1:0] t0_q, t1_q, s_q, y_q, r_q;
	logic                rsat_q;
	logic [W-1:0]        ma_q, mb_q, den_q, rem_q;
	logic                neg_q;
	logic [PW-1:0]       acc_q;
	logic [CW-1:0]       cnt_q;
	logic [NW-1:0]       dvd_q;
	logic [sekf_pkg::OUT_W-1:0] out_q;
	logic                out_valid_q;

	logic                in_fire;
	logic                mul_go, div_go, out_load;
	logic [W-1:0]        mul_a, mul_b;
	logic [W-1:0]        add_a, add_b;
	logic                add_sub;

	assign in_fire   = s_tvalid && s_tready;
	assign s_tready  = (state_q == sekf_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	// shared saturating adder
	logic [W:0]          add_sum;
	logic                add_sat;
	logic signed [W-1:0] add_res;
	always_comb begin
		if (add_sub) begin
			add_sum = {add_a[W-1], add_a} - {add_b[W-1], add_b};
		end else begin
			add_sum = {add_a[W-1], add_a} + {add_b[W-1], add_b};
		end
		add_sat = add_sum[W] != add_sum[W-1];
		if (add_sat) begin
			add_res = add_sum[W] ? sekf_pkg::LIM_NEG : sekf_pkg::LIM_POS;
		end else begin
			add_res = add_sum[W-1:0];
		end
	end

	// partial product of the shared multiplier
	logic [HW-1:0] pp_a, pp_b;
	logic [W-1:0]  pp;
	logic [5:0]    pp_sh;
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				pp_a = ma_q[HW-1:0];
				pp_b = mb_q[HW-1:0];
				pp_sh = 6'd0;
			end
			2'd1: begin
				pp_a = ma_q[HW-1:0];
				pp_b = mb_q[W-1:HW];
				pp_sh = 6'(HW);
			end
			2'd2: begin
				pp_a = ma_q[W-1:HW];
				pp_b = mb_q[HW-1:0];
				pp_sh = 6'(HW);
			end
			default: begin
				pp_a = ma_q[W-1:HW];
				pp_b = mb_q[W-1:HW];
				pp_sh = 6'(W);
			end
		endcase
		pp = pp_a * pp_b;
	end

	// multiplier rounding and saturation
	logic [PW-1:0]       m_rsum, m_rnd;
	logic [W-1:0]        lim;
	logic                m_sat;
	logic signed [W-1:0] mul_res;
	always_comb begin
		lim     = neg_q ? sekf_pkg::LIM_NEG : sekf_pkg::LIM_POS;
		m_rsum  = acc_q + (PW'(1) << (FRAC_BITS - 1));
		m_rnd   = m_rsum >> FRAC_BITS;
		m_sat   = m_rnd > PW'(lim);
		mul_res = apply_sign(m_sat ? lim : m_rnd[W-1:0], neg_q);
	end

	// divider step and final rounding
	logic [W:0]          d_r2, d_diff;
	logic                d_ge, d_up, d_sat;
	logic [NW:0]         d_qf;
	logic signed [W-1:0] div_res;
	always_comb begin
		d_r2    = {rem_q, dvd_q[NW-1]};
		d_diff  = d_r2 - {1'b0, den_q};
		d_ge    = d_r2 >= {1'b0, den_q};
		d_up    = {rem_q, 1'b0} >= {1'b0, den_q};
		d_qf    = {1'b0, dvd_q} + (NW+1)'(d_up);
		d_sat   = d_qf > (NW+1)'(lim);
		div_res = apply_sign(d_sat ? lim : d_qf[W-1:0], neg_q);
	end

	// clamp of the updated state, upper bound first
	logic signed [W-1:0] cl_hi, cl_res;
	always_comb begin
		cl_hi  = (t1_q > hi_q) ? hi_q : t1_q;
		cl_res = (cl_hi < lo_q) ? lo_q : cl_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sekf_pkg::ST_IDLE;
			ret_q   <= sekf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		mul_go   = 1'b0;
		div_go   = 1'b0;
		out_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		add_a    = '0;
		add_b    = '0;
		add_sub  = 1'b0;
		case (state_q)
			sekf_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (s_tuser)
						sekf_pkg::KIND_PREDICT: state_d = sekf_pkg::ST_PR_FX;
						sekf_pkg::KIND_UPDATE:  state_d = sekf_pkg::ST_UP_PH;
						default:                state_d = sekf_pkg::ST_DONE;
					endcase
				end
			end
			sekf_pkg::ST_MUL: begin
				if (cnt_q == CW'(sekf_pkg::MUL_STEPS - 1)) begin
					state_d = sekf_pkg::ST_MULR;
				end
			end
			sekf_pkg::ST_MULR: state_d = ret_q;
			sekf_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = sekf_pkg::ST_DIVR;
				end
			end
			sekf_pkg::ST_DIVR: state_d = sekf_pkg::ST_UP_KY;
			sekf_pkg::ST_PR_FX: begin
				mul_go = 1'b1; mul_a = f_q; mul_b = x_q;
				ret_d = sekf_pkg::ST_PR_BU; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_PR_BU: begin
				mul_go = 1'b1; mul_a = b_q; mul_b = u_q;
				ret_d = sekf_pkg::ST_PR_X; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_PR_X: begin
				add_a = t0_q; add_b = r_q;
				state_d = sekf_pkg::ST_PR_FP;
			end
			sekf_pkg::ST_PR_FP: begin
				mul_go = 1'b1; mul_a = f_q; mul_b = p_q;
				ret_d = sekf_pkg::ST_PR_PF; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_PR_PF: begin
				mul_go = 1'b1; mul_a = r_q; mul_b = f_q;
				ret_d = sekf_pkg::ST_PR_Q; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_PR_Q: begin
				add_a = r_q; add_b = {1'b0, qn_q};
				state_d = sekf_pkg::ST_DONE;
			end
			sekf_pkg::ST_UP_PH: begin
				mul_go = 1'b1; mul_a = p_q; mul_b = h_q;
				ret_d = sekf_pkg::ST_UP_HP; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_UP_HP: begin
				mul_go = 1'b1; mul_a = h_q; mul_b = r_q;
				ret_d = sekf_pkg::ST_UP_S; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_UP_S: begin
				add_a = r_q; add_b = {1'b0, rn_q};
				state_d = sekf_pkg::ST_UP_Y;
			end
			sekf_pkg::ST_UP_Y: begin
				add_a = z_q; add_b = hx_q; add_sub = 1'b1;
				state_d = sekf_pkg::ST_UP_K;
			end
			sekf_pkg::ST_UP_K: begin
				// zero S keeps the held gain
				if (s_q != '0) begin
					div_go = 1'b1;
					state_d = sekf_pkg::ST_DIV;
				end else begin
					state_d = sekf_pkg::ST_UP_KY;
				end
			end
			sekf_pkg::ST_UP_KY: begin
				mul_go = 1'b1; mul_a = k_q; mul_b = y_q;
				ret_d = sekf_pkg::ST_UP_X; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_UP_X: begin
				add_a = x_q; add_b = r_q;
				state_d = sekf_pkg::ST_UP_CL;
			end
			sekf_pkg::ST_UP_CL: begin
				mul_go = 1'b1; mul_a = k_q; mul_b = h_q;
				ret_d = sekf_pkg::ST_UP_IKH; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_UP_IKH: begin
				add_a = FX_ONE; add_b = r_q; add_sub = 1'b1;
				state_d = sekf_pkg::ST_UP_P;
			end
			sekf_pkg::ST_UP_P: begin
				mul_go = 1'b1; mul_a = p_q; mul_b = t1_q;
				ret_d = sekf_pkg::ST_UP_PW; state_d = sekf_pkg::ST_MUL;
			end
			sekf_pkg::ST_UP_PW: state_d = sekf_pkg::ST_DONE;
			sekf_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d = sekf_pkg::ST_IDLE;
				end
			end
			default: state_d = sekf_pkg::ST_IDLE;
		endcase
	end

	// filter state, configuration, output and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			p_q         <= '0;
			k_q         <= '0;
			ovf_q       <= 1'b0;
			ps_q        <= 1'b0;
			qn_q        <= '0;
			rn_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					sekf_pkg::CFG_PROCESS_NOISE:     qn_q <= cfg_data;
					sekf_pkg::CFG_MEASUREMENT_NOISE: rn_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_go) begin
				cnt_q <= '0;
			end else if (div_go) begin
				cnt_q <= CW'(NW - 1);
			end else if (state_q == sekf_pkg::ST_MUL) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == sekf_pkg::ST_DIV) begin
				cnt_q <= cnt_q - CW'(1);
			end
			case (state_q)
				sekf_pkg::ST_IDLE: begin
					if (in_fire && s_tuser == sekf_pkg::KIND_INIT) begin
						x_q   <= s_tdata[9*W-1:8*W];
						p_q   <= {1'b0, s_tdata[9*W+sekf_pkg::NOISE_W-1:9*W]};
						ovf_q <= 1'b0;
					end
				end
				sekf_pkg::ST_DIVR: k_q <= div_res;
				sekf_pkg::ST_PR_FX: ps_q <= 1'b0;
				sekf_pkg::ST_PR_X: begin
					x_q <= add_res;
					// an overflowed covariance restarts from zero
					if (ovf_q) begin
						p_q <= '0;
					end
				end
				sekf_pkg::ST_PR_PF: ps_q <= rsat_q;
				sekf_pkg::ST_PR_Q: begin
					p_q   <= add_res;
					ovf_q <= ps_q || rsat_q || add_sat;
				end
				sekf_pkg::ST_UP_CL: x_q <= cl_res;
				sekf_pkg::ST_UP_PW: begin
					p_q <= r_q;
					if (rsat_q) begin
						ovf_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			u_q  <= s_tdata[1*W-1:0*W];
			f_q  <= s_tdata[2*W-1:1*W];
			b_q  <= s_tdata[3*W-1:2*W];
			z_q  <= s_tdata[4*W-1:3*W];
			hx_q <= s_tdata[5*W-1:4*W];
			h_q  <= s_tdata[6*W-1:5*W];
			lo_q <= s_tdata[7*W-1:6*W];
			hi_q <= s_tdata[8*W-1:7*W];
			s_q  <= '0;
			y_q  <= '0;
		end
		if (mul_go) begin
			ma_q  <= mag(mul_a);
			mb_q  <= mag(mul_b);
			neg_q <= mul_a[W-1] ^ mul_b[W-1];
			acc_q <= '0;
		end
		if (div_go) begin
			den_q <= mag(s_q);
			dvd_q <= NW'(mag(t0_q)) << FRAC_BITS;
			rem_q <= '0;
			neg_q <= t0_q[W-1] ^ s_q[W-1];
		end
		case (state_q)
			sekf_pkg::ST_MUL: acc_q <= acc_q + (PW'(pp) << pp_sh);
			sekf_pkg::ST_MULR: begin
				r_q    <= mul_res;
				rsat_q <= m_sat;
			end
			sekf_pkg::ST_DIV: begin
				rem_q <= d_ge ? d_diff[W-1:0] : d_r2[W-1:0];
				dvd_q <= {dvd_q[NW-2:0], d_ge};
			end
			sekf_pkg::ST_PR_BU: t0_q <= r_q;
			sekf_pkg::ST_UP_HP: t0_q <= r_q;
			sekf_pkg::ST_UP_S: s_q <= add_res;
			sekf_pkg::ST_UP_Y: y_q <= add_res;
			sekf_pkg::ST_UP_X: t1_q <= add_res;
			sekf_pkg::ST_UP_IKH: t1_q <= add_res;
			default: ;
		endcase
		if (out_load) begin
			out_q <= {s_q, y_q, k_q, p_q, x_q};
		end
	end

endmodule

>>> hdl/sekf_checker.sv
// Port-level checks for the scalar extended Kalman filter, bound to the top level.
module sekf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [sekf_pkg::OUT_W-1:0] m_tdata
);

	// one step in work at a time: input closes right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready stayed high after a transaction");

	// a new result is posted only as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result posted while a step is still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before its transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind scalar_extended_kalman_filter sekf_checker u_sekf_checker (.*);

>>> dv/tb_scalar_extended_kalman_filter.sv
// Self-checking testbench of the scalar extended Kalman filter with a bit-exact step predictor.
module tb_scalar_extended_kalman_filter;

	localparam int FRAC = 32;
	localparam logic [sekf_pkg::KIND_W-1:0] KIND_HOLD = 2'd3;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int TRACK_ITEMS = 200;

	typedef logic signed [sekf_pkg::WORD_W-1:0] word_t;

	localparam word_t WMAX = sekf_pkg::LIM_POS;
	localparam word_t WMIN = sekf_pkg::LIM_NEG;
	localparam word_t ONE = word_t'(64'd1 << FRAC);
	localparam logic [sekf_pkg::NOISE_W-1:0] NOISE_MAX = {sekf_pkg::NOISE_W{1'b1}};

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic                         pad;
		logic [sekf_pkg::NOISE_W-1:0] init_cov;
		word_t                        init_x;
		word_t                        x_high;
		word_t                        x_low;
		word_t                        sens;
		word_t                        pred_out;
		word_t                        meas;
		word_t                        ctl_gain;
		word_t                        trans;
		word_t                        drive;
	} step_t;

	// m_tdata layout, lowest field last
	typedef struct packed {
		word_t innov;
		word_t resid;
		word_t gain;
		word_t cov;
		word_t est;
	} result_t;

	typedef struct {
		bit                             is_cfg;
		logic [sekf_pkg::CFG_IDX_W-1:0] cfg_idx;
		logic [sekf_pkg::NOISE_W-1:0]   cfg_val;
		logic [sekf_pkg::KIND_W-1:0]    kind;
		step_t                          fields;
		bit                             typed;
		result_t                        want;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [sekf_pkg::IN_W-1:0]      s_tdata;
	logic [sekf_pkg::KIND_W-1:0]    s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [sekf_pkg::OUT_W-1:0]     m_tdata;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [sekf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sekf_pkg::NOISE_W-1:0]   cfg_data;

	// predictor state
	word_t est_x, est_p, held_gain, q_noise, r_noise;
	bit    p_overflow;

	result_t pending_outputs[$];
	int      mismatches = 0;
	bit      quiet = 0;
	bit      long_hold = 0;
	string   field_name[5] = '{"state_estimate", "covariance", "gain", "residual",
		"innovation_variance"};

	scalar_extended_kalman_filter #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1000000);
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------- fixed point predictor ----------------

	function automatic logic [127:0] mag_of(word_t v);
		return (v < 0) ? 128'(-longint'(v)) : 128'(longint'(v));
	endfunction

	function automatic word_t from_mag(logic [127:0] m, bit neg, inout bit sat);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
		if (m > lim) begin
			sat = 1;
			m = lim;
		end
		return neg ? -word_t'(m[sekf_pkg::WORD_W-1:0]) : word_t'(m[sekf_pkg::WORD_W-1:0]);
	endfunction

	function automatic word_t clip(longint v, inout bit sat);
		if (v > longint'(WMAX)) begin
			sat = 1;
			return WMAX;
		end
		if (v < longint'(WMIN)) begin
			sat = 1;
			return WMIN;
		end
		return word_t'(v);
	endfunction

	function automatic word_t fx_add(word_t a, word_t b, inout bit sat);
		return clip(longint'(a) + longint'(b), sat);
	endfunction

	function automatic word_t fx_sub(word_t a, word_t b, inout bit sat);
		return clip(longint'(a) - longint'(b), sat);
	endfunction

	// magnitude product, rounded half away from zero
	function automatic word_t fx_mul(word_t a, word_t b, inout bit sat);
		logic [127:0] p;
		p = mag_of(a) * mag_of(b) + (128'd1 << (FRAC - 1));
		return from_mag(p >> FRAC, (a < 0) != (b < 0), sat);
	endfunction

	function automatic word_t fx_div(word_t num, word_t den, inout bit sat);
		logic [127:0] n, d, q, r;
		n = mag_of(num) << FRAC;
		d = mag_of(den);
		q = n / d;
		r = n % d;
		if (q > 128'h1_0000_0000_0000) q = '1;
		else if (r >= d - r) q = q + 1;
		return from_mag(q, (num < 0) != (den < 0), sat);
	endfunction

	function automatic result_t filter_step(logic [sekf_pkg::KIND_W-1:0] kind, step_t s);
		result_t r;
		bit junk, ps;
		word_t t, pht, v, ikh, f, h, lo, hi;
		junk = 0;
		ps = 0;
		r = '0;
		f = s.trans;
		h = s.sens;
		lo = s.x_low;
		hi = s.x_high;
		case (kind)
			sekf_pkg::KIND_PREDICT: begin
				est_x = fx_add(fx_mul(f, est_x, junk), fx_mul(s.ctl_gain, s.drive, junk), junk);
				if (p_overflow) est_p = '0;
				t = fx_mul(f, est_p, ps);
				t = fx_mul(t, f, ps);
				est_p = fx_add(t, q_noise, ps);
				p_overflow = ps;
			end
			sekf_pkg::KIND_UPDATE: begin
				pht = fx_mul(est_p, h, junk);
				r.innov = fx_add(fx_mul(h, pht, junk), r_noise, junk);
				if (r.innov != 0) held_gain = fx_div(pht, r.innov, junk);
				r.resid = fx_sub(s.meas, s.pred_out, junk);
				v = fx_add(est_x, fx_mul(held_gain, r.resid, junk), junk);
				// upper bound first, so crossed bounds leave the lower one
				if (v > hi) v = hi;
				if (v < lo) v = lo;
				est_x = v;
				ikh = fx_sub(ONE, fx_mul(held_gain, h, junk), junk);
				est_p = fx_mul(est_p, ikh, ps);
				if (ps) p_overflow = 1;
			end
			sekf_pkg::KIND_INIT: begin
				est_x = s.init_x;
				est_p = word_t'({1'b0, s.init_cov});
				p_overflow = 0;
			end
			default: ;
		endcase
		r.est = est_x;
		r.cov = est_p;
		r.gain = held_gain;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic word_t rand_full();
		return word_t'({$urandom, $urandom});
	endfunction

	// signed value from -2^bits up to below 2^bits
	function automatic word_t rand_near(int bits);
		return rand_full() >>> (sekf_pkg::WORD_W - 1 - bits);
	endfunction

	function automatic step_t wild_fields();
		step_t w;
		for (int i = 0; i < sekf_pkg::IN_W / 32; i++) w[i*32 +: 32] = $urandom;
		w.pad = 1'b0;
		return w;
	endfunction

	function automatic step_t pred_fields(word_t f, word_t b, word_t u);
		step_t s;
		s = wild_fields();
		s.trans = f;
		s.ctl_gain = b;
		s.drive = u;
		return s;
	endfunction

	function automatic step_t upd_fields(word_t z, word_t hx, word_t h, word_t lo, word_t hi);
		step_t s;
		s = wild_fields();
		s.meas = z;
		s.pred_out = hx;
		s.sens = h;
		s.x_low = lo;
		s.x_high = hi;
		return s;
	endfunction

	function automatic step_t init_fields(word_t x, logic [sekf_pkg::NOISE_W-1:0] p);
		step_t s;
		s = wild_fields();
		s.init_x = x;
		s.init_cov = p;
		return s;
	endfunction

	function automatic row_t step_row(logic [sekf_pkg::KIND_W-1:0] k, step_t s);
		row_t r;
		r = '{default: '0};
		r.kind = k;
		r.fields = s;
		return r;
	endfunction

	function automatic row_t typed(row_t r, word_t e, word_t c, word_t g);
		r.typed = 1;
		r.want = '{innov: '0, resid: '0, gain: g, cov: c, est: e};
		return r;
	endfunction

	function automatic row_t cfg_row(logic [sekf_pkg::CFG_IDX_W-1:0] idx,
		logic [sekf_pkg::NOISE_W-1:0] val);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic logic [sekf_pkg::NOISE_W-1:0] noise_for(int phase);
		case (phase)
			1: return '0;
			2: return NOISE_MAX;
			3: return sekf_pkg::NOISE_W'({$urandom, $urandom});
			default: return sekf_pkg::NOISE_W'($urandom_range(0, 1 << 26));
		endcase
	endfunction

	task automatic send_item(logic [sekf_pkg::KIND_W-1:0] kind, step_t s, bit use_typed,
		result_t want);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid = 0;
			end
		end
		@(negedge clk);
		s_tvalid = 1;
		s_tdata = s;
		s_tuser = kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = use_typed ? want : filter_step(kind, s);
		if (use_typed) void'(filter_step(kind, s));
		pending_outputs.push_back(want);
	endtask

	// registers change only with the filter drained
	task automatic write_noise(logic [sekf_pkg::CFG_IDX_W-1:0] idx,
		logic [sekf_pkg::NOISE_W-1:0] val);
		@(negedge clk);
		s_tvalid = 0;
		while (pending_outputs.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == sekf_pkg::CFG_PROCESS_NOISE) q_noise = word_t'({1'b0, val});
		else r_noise = word_t'({1'b0, val});
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// init followed by a plausible predict/update sequence with some noise mixed in
	task automatic run_track(int n);
		step_t s;
		logic [sekf_pkg::KIND_W-1:0] k;
		word_t h, lo, hi;
		s = init_fields(rand_near(34), sekf_pkg::NOISE_W'($urandom) << $urandom_range(0, 6));
		send_item(sekf_pkg::KIND_INIT, s, 0, '0);
		repeat (n - 1) begin
			if ($urandom_range(0, 9) == 0) begin
				k = sekf_pkg::KIND_W'($urandom_range(0, 3));
				s = wild_fields();
			end else if ($urandom_range(0, 1) == 0) begin
				k = sekf_pkg::KIND_PREDICT;
				s = pred_fields(ONE + rand_near(29), rand_near(32), rand_near(34));
			end else begin
				k = sekf_pkg::KIND_UPDATE;
				h = ($urandom_range(0, 3) == 0) ? rand_near(33) : ONE + rand_near(30);
				if ($urandom_range(0, 7) == 0) begin
					lo = rand_near(34);
					hi = rand_near(34);
				end else begin
					lo = WMIN;
					hi = WMAX;
				end
				s = upd_fields(rand_near(35), rand_near(35), h, lo, hi);
			end
			send_item(k, s, 0, '0);
		end
	endtask

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
	endtask

	// ---------------- result checking ----------------

	always @(posedge clk) begin : watch_results
		logic [sekf_pkg::OUT_W-1:0] got, want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got = m_tdata;
			if (pending_outputs.size() == 0) begin
				note_mismatch($sformatf("unexpected transaction %h", got));
			end else begin
				want = pending_outputs.pop_front();
				for (int f = 0; f < 5; f++)
					if (got[f*sekf_pkg::WORD_W +: sekf_pkg::WORD_W] !==
						want[f*sekf_pkg::WORD_W +: sekf_pkg::WORD_W])
						note_mismatch($sformatf("%s expected %h got %h", field_name[f],
							want[f*sekf_pkg::WORD_W +: sekf_pkg::WORD_W],
							got[f*sekf_pkg::WORD_W +: sekf_pkg::WORD_W]));
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin : drain
		int stall_left;
		stall_left = 0;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 15);
				m_tready = 0;
			end else begin
				m_tready = 1;
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin : stimulus
		row_t directed[$];
		int left, n;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = sekf_pkg::KIND_PREDICT;
		cfg_valid = 0;
		cfg_index = sekf_pkg::CFG_PROCESS_NOISE;
		cfg_data = '0;
		est_x = '0;
		est_p = '0;
		held_gain = '0;
		q_noise = '0;
		r_noise = '0;
		p_overflow = 0;

		// no change after reset: everything reads zero
		directed.push_back(typed(step_row(KIND_HOLD, wild_fields()), '0, '0, '0));
		directed.push_back(typed(step_row(sekf_pkg::KIND_INIT, init_fields(WMAX, NOISE_MAX)),
			WMAX, word_t'({1'b0, NOISE_MAX}), '0));
		directed.push_back(typed(step_row(sekf_pkg::KIND_INIT, init_fields(WMIN, '0)),
			WMIN, '0, '0));
		directed.push_back(step_row(sekf_pkg::KIND_PREDICT, pred_fields(ONE, ONE, ONE)));
		directed.push_back(step_row(sekf_pkg::KIND_INIT,
			init_fields('0, sekf_pkg::NOISE_W'(2 * ONE))));
		directed.push_back(step_row(sekf_pkg::KIND_UPDATE,
			upd_fields(3 * ONE, ONE, ONE, WMIN, WMAX)));
		// zero innovation variance: gain held
		directed.push_back(step_row(sekf_pkg::KIND_UPDATE, upd_fields(ONE, '0, '0, WMIN, WMAX)));
		directed.push_back(step_row(sekf_pkg::KIND_INIT,
			init_fields(ONE, sekf_pkg::NOISE_W'(3 * ONE))));
		// covariance saturates, next predict starts from a cleared covariance
		directed.push_back(step_row(sekf_pkg::KIND_PREDICT, pred_fields(WMAX, '0, '0)));
		directed.push_back(step_row(sekf_pkg::KIND_PREDICT, pred_fields(ONE, WMIN, WMIN)));
		// crossed clamps
		directed.push_back(step_row(sekf_pkg::KIND_UPDATE,
			upd_fields(ONE, -ONE, ONE, 5 * ONE, -5 * ONE)));
		directed.push_back(step_row(sekf_pkg::KIND_UPDATE,
			upd_fields(WMAX, WMIN, WMIN, WMIN, WMAX)));
		directed.push_back(step_row(sekf_pkg::KIND_INIT, init_fields(-ONE, NOISE_MAX)));
		directed.push_back(step_row(sekf_pkg::KIND_UPDATE,
			upd_fields(WMIN, WMAX, -100 * ONE, WMIN, WMAX)));
		directed.push_back(cfg_row(sekf_pkg::CFG_PROCESS_NOISE, NOISE_MAX));
		directed.push_back(cfg_row(sekf_pkg::CFG_MEASUREMENT_NOISE, NOISE_MAX));
		directed.push_back(step_row(sekf_pkg::KIND_PREDICT, pred_fields(WMIN, WMAX, WMIN)));
		directed.push_back(step_row(sekf_pkg::KIND_UPDATE, upd_fields('0, '0, ONE, WMIN, WMAX)));
		directed.push_back(step_row(KIND_HOLD, wild_fields()));
		directed.push_back(cfg_row(sekf_pkg::CFG_PROCESS_NOISE, '0));
		directed.push_back(cfg_row(sekf_pkg::CFG_MEASUREMENT_NOISE, sekf_pkg::NOISE_W'(1)));
		directed.push_back(step_row(sekf_pkg::KIND_INIT,
			init_fields(ONE, sekf_pkg::NOISE_W'(ONE))));
		directed.push_back(step_row(sekf_pkg::KIND_UPDATE,
			upd_fields(2 * ONE, ONE, -ONE, -4 * ONE, 4 * ONE)));
		directed.push_back(step_row(sekf_pkg::KIND_PREDICT, pred_fields(-ONE, ONE, ONE)));
		directed.push_back(step_row(sekf_pkg::KIND_UPDATE, upd_fields('0, '0, '0, WMIN, WMAX)));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				write_noise(directed[i].cfg_idx, directed[i].cfg_val);
			else
				send_item(directed[i].kind, directed[i].fields, directed[i].typed,
					directed[i].want);
		end

		for (int phase = 0; phase < 6; phase++) begin
			write_noise(sekf_pkg::CFG_PROCESS_NOISE, noise_for(phase));
			write_noise(sekf_pkg::CFG_MEASUREMENT_NOISE, noise_for(phase));
			if (phase == 2) long_hold = 1;
			if (phase == 5) quiet = 1;
			left = TRACK_ITEMS;
			while (left > 0) begin
				n = $urandom_range(4, 24);
				if (n > left) n = left;
				run_track(n);
				left -= n;
			end
		end

		@(negedge clk);
		s_tvalid = 0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0 && pending_outputs.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hdl/sekf_pkg.sv
hdl/scalar_extended_kalman_filter.sv
hdl/sekf_checker.sv
dv/tb_scalar_extended_kalman_filter.sv
